// ----- src/cnlc_pkg.sv -----
// Shared constants, types and the Luhn digit function of the card number classifier.
package cnlc_pkg;

  localparam int IN_W           = 54;
  localparam int IN_PAD_W       = 56;
  localparam int OUT_PAD_W      = 8;
  localparam int MAX_DIGITS_DEF = 17;
  localparam int COUNT_W        = 5;
  localparam int BITCNT_W       = 6;

  typedef enum logic [1:0] {
    CARD_INVALID,
    CARD_AMEX,
    CARD_MASTERCARD,
    CARD_VISA
  } card_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    card_type_t         card_type;
    logic               luhn_ok;
    logic [COUNT_W-1:0] digit_count;
  } cnlc_result_t;

  function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic alt);
    logic [4:0] dbl;
    logic [4:0] red;
    dbl = {d, 1'b0};
    red = dbl - 5'd9;
    if (!alt) begin
      luhn_term = d;
    end else if (d >= 4'd5) begin
      luhn_term = red[3:0];
    end else begin
      luhn_term = dbl[3:0];
    end
  endfunction

endpackage

// ----- src/cnlc_bcd_conv.sv -----
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module cnlc_bcd_conv #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cnlc_pkg::IN_W-1:0] number,
  output logic                      done,
  output logic [4*MAX_DIGITS-1:0]   bcd,
  output logic                      overflow
);
  import cnlc_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;

  logic [IN_W-1:0]     sh;
  logic                run;
  logic [BITCNT_W-1:0] cnt;
  logic [BCD_W-1:0]    corr;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == BITCNT_W'(IN_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == BITCNT_W'(IN_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh       <= number;
      bcd      <= '0;
      overflow <= 1'b0;
    end else if (run) begin
      bcd      <= {corr[BCD_W-2:0], sh[IN_W-1]};
      sh       <= {sh[IN_W-2:0], 1'b0};
      overflow <= overflow | corr[BCD_W-1];
    end
  end

endmodule

// ----- src/cnlc_luhn_scan.sv -----
// Digit-serial Luhn sum, digit count, prefix capture and issuer classification.
module cnlc_luhn_scan #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [4*MAX_DIGITS-1:0]    bcd,
  input  logic                       overflow,
  output logic                       done,
  output cnlc_pkg::cnlc_result_t     result
);
  import cnlc_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;

  logic [BCD_W-1:0]   sh;
  logic               run;
  logic               fin;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] cnt;
  logic [3:0]         acc;
  logic [3:0]         d1;
  logic [3:0]         d0;
  logic [3:0]         prev;
  logic               ovf;
  logic [3:0]         dig;
  logic [3:0]         term;
  logic [4:0]         sum;
  logic [3:0]         acc_next;
  cnlc_result_t       result_next;
  logic               amex;
  logic               master;
  logic               visa;

  always_comb begin
    dig  = sh[3:0];
    term = luhn_term(dig, idx[0]);
    sum  = {1'b0, acc} + {1'b0, term};
    if (sum >= 5'd10) begin
      acc_next = 4'(sum - 5'd10);
    end else begin
      acc_next = sum[3:0];
    end
  end

  always_comb begin
    amex   = (cnt == COUNT_W'(15)) && (d1 == 4'd3) && ((d0 == 4'd4) || (d0 == 4'd7));
    master = (cnt == COUNT_W'(16)) && (d1 == 4'd5) && (d0 >= 4'd1) && (d0 <= 4'd5);
    visa   = ((cnt == COUNT_W'(13)) || (cnt == COUNT_W'(16))) && (d1 == 4'd4);
    result_next.luhn_ok     = (acc == 4'd0);
    result_next.digit_count = ovf ? COUNT_W'(MAX_DIGITS) : cnt;
    if (!result_next.luhn_ok || ovf) begin
      result_next.card_type = CARD_INVALID;
    end else if (amex) begin
      result_next.card_type = CARD_AMEX;
    end else if (master) begin
      result_next.card_type = CARD_MASTERCARD;
    end else if (visa) begin
      result_next.card_type = CARD_VISA;
    end else begin
      result_next.card_type = CARD_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= fin;
      fin  <= !start && run && (idx == COUNT_W'(MAX_DIGITS - 1));
      if (start) begin
        run <= 1'b1;
        idx <= '0;
      end else if (run) begin
        idx <= idx + 1'b1;
        if (idx == COUNT_W'(MAX_DIGITS - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= bcd;
      ovf  <= overflow;
      acc  <= '0;
      cnt  <= '0;
      d1   <= '0;
      d0   <= '0;
      prev <= '0;
    end else if (run) begin
      sh   <= {4'd0, sh[BCD_W-1:4]};
      acc  <= acc_next;
      prev <= dig;
      if (dig != 4'd0) begin
        cnt <= idx + 1'b1;
        d1  <= dig;
        d0  <= prev;
      end
    end
    if (fin) begin
      result <= result_next;
    end
  end

endmodule

// ----- src/card_number_luhn_classifier.sv -----
// Top level of the card number classifier: stream ports, sequencing and output register.
//
// Channel   Direction  Transfer                 Payload
// s_axis    in         one card number          tdata[53:0] pan
// m_axis    out        one result per number    tdata[1:0] card_type, [2] luhn_ok,
//                                               [7:3] digit_count
//
// Each number passes from acceptance through the bit-serial BCD conversion and the
// digit-serial scan into the output register, where its result becomes valid.
// One number is in work at a time; a new one is accepted once the previous result
// has reached the output register, even if that result has not yet been taken.
// Reset is synchronous and clears the sequencer and the output valid flag.
module card_number_luhn_classifier #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cnlc_pkg::IN_PAD_W-1:0]  s_axis_tdata,  // [53:0] pan
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cnlc_pkg::OUT_PAD_W-1:0] m_axis_tdata   // [1:0] card_type, [2] luhn_ok,
                                                        // [7:3] digit_count
);
  import cnlc_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic                    accept;
  logic                    conv_done;
  logic [4*MAX_DIGITS-1:0] bcd;
  logic                    overflow;
  logic                    scan_done;
  cnlc_result_t            scan_res;
  cnlc_result_t            out_res;
  logic                    out_free;
  logic                    load_out;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  cnlc_bcd_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .number   (s_axis_tdata[IN_W-1:0]),
    .done     (conv_done),
    .bcd      (bcd),
    .overflow (overflow)
  );

  cnlc_luhn_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_done),
    .bcd      (bcd),
    .overflow (overflow),
    .done     (scan_done),
    .result   (scan_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_SCAN: begin
        load_out = scan_done && out_free;
      end
      ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= scan_res;
    end
  end

  assign m_axis_tdata = {out_res.digit_count, out_res.luhn_ok, out_res.card_type};

endmodule

// ----- sim/testbench.sv -----
// Self-checking stream testbench for the card number classifier with a built-in Luhn predictor.
`timescale 1ns / 100ps

module testbench;
  import cnlc_pkg::*;

  typedef struct {
    card_type_t         kind;
    logic               luhn;
    logic [COUNT_W-1:0] ndig;
  } verdict_t;

  typedef struct {
    logic [IN_W-1:0] num;
    bit              drain;
  } card_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_PAD_W-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_PAD_W-1:0] m_axis_tdata;
  logic                 rx_hold = 1'b0;

  card_item_t card_q[$];
  verdict_t   verdict_q[$];
  int         n_accepted = 0;
  int         n_results = 0;
  int         n_err = 0;
  int         tx_gap = 0;
  int         rx_wait = 0;

  card_number_luhn_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic verdict_t classify(input logic [IN_W-1:0] card);
    longint unsigned n;
    int unsigned     d;
    int unsigned     sum;
    int unsigned     lead;
    int unsigned     second;
    int unsigned     prefix;
    int unsigned     cnt;
    bit              dbl;
    verdict_t        r;
    n = 64'(card);
    sum = 0;
    cnt = 0;
    dbl = 1'b0;
    lead = 0;
    second = 0;
    while (n != 0 && cnt < MAX_DIGITS_DEF) begin
      d = 32'(n % 10);
      n = n / 10;
      second = lead;
      lead = d;
      cnt++;
      if (dbl) begin
        d = 2 * d;
        if (d > 9) d = d - 9;
      end
      sum += d;
      dbl = !dbl;
    end
    prefix = (cnt >= 2) ? lead * 10 + second : lead;
    r.kind = CARD_INVALID;
    r.luhn = (sum % 10 == 0);
    r.ndig = COUNT_W'(cnt);
    if (r.luhn && n == 0) begin
      if (cnt == 15 && (prefix == 34 || prefix == 37)) begin
        r.kind = CARD_AMEX;
      end else if (cnt == 16 && prefix >= 51 && prefix <= 55) begin
        r.kind = CARD_MASTERCARD;
      end else if ((cnt == 13 || cnt == 16) && prefix / 10 == 4) begin
        r.kind = CARD_VISA;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned card_digits(input longint unsigned lead, input int lead_len,
                                                  input int total_len);
    longint unsigned v;
    v = lead;
    for (int i = lead_len; i < total_len; i++) v = v * 10 + 64'($urandom_range(0, 9));
    return v;
  endfunction

  // Replaces the check digit so that the Luhn sum passes or fails as asked.
  function automatic longint unsigned luhn_set(input longint unsigned v, input bit valid);
    longint unsigned base;
    longint unsigned cand;
    int              d;
    verdict_t        r;
    base = v - v % 10;
    d = $urandom_range(0, 9);
    for (int i = 0; i < 10; i++) begin
      cand = base + 64'((d + i) % 10);
      r = classify(cand[IN_W-1:0]);
      if (r.luhn == valid) return cand;
    end
    return v;
  endfunction

  task automatic add_card(input longint unsigned v, input bit drain = 1'b0);
    card_item_t it;
    it.num = v[IN_W-1:0];
    it.drain = drain;
    card_q.push_back(it);
  endtask

  always @(posedge clk) begin : sender
    card_item_t nxt;
    logic       offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(classify(s_axis_tdata[IN_W-1:0]));
        n_accepted++;
        offer = 1'b0;
        tx_gap = ((n_accepted / 150) % 3 == 1) ? 0 : $urandom_range(0, 13);
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (card_q.size() != 0 &&
                     !(card_q[0].drain && (verdict_q.size() != 0 || m_axis_tvalid))) begin
          nxt = card_q.pop_front();
          s_axis_tdata <= {{(IN_PAD_W-IN_W){1'b0}}, nxt.num};
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  always @(posedge clk) begin : receiver
    verdict_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no card number pending: tdata %h", m_axis_tdata);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[1:0] !== want.kind) begin
            $error("card_type: expected %0d, actual %0d", want.kind, m_axis_tdata[1:0]);
            n_err++;
          end
          if (m_axis_tdata[2] !== want.luhn) begin
            $error("luhn_ok: expected %0d, actual %0d", want.luhn, m_axis_tdata[2]);
            n_err++;
          end
          if (m_axis_tdata[7:3] !== want.ndig) begin
            $error("digit_count: expected %0d, actual %0d", want.ndig, m_axis_tdata[7:3]);
            n_err++;
          end
        end
        rx_wait = ((n_results / 130) % 3 == 2) ? 0 : $urandom_range(0, 13);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  initial begin : rx_holdoff
    wait (n_accepted >= 500);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (1000) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    longint unsigned v;
    int              pick;
    int              len;
    add_card(0);
    add_card(1);
    add_card(4);
    add_card(9);
    add_card(18);
    add_card(34);
    add_card({IN_W{1'b1}});
    add_card(64'd1 << (IN_W - 1));
    add_card(64'd10000000000000000);
    add_card(luhn_set(64'd12345678901234567, 1'b1));
    add_card(luhn_set(card_digits(34, 2, 15), 1'b1));
    add_card(luhn_set(card_digits(37, 2, 15), 1'b1));
    add_card(luhn_set(card_digits(35, 2, 15), 1'b1));
    add_card(luhn_set(card_digits(34, 2, 15), 1'b0));
    add_card(luhn_set(card_digits(51, 2, 16), 1'b1));
    add_card(luhn_set(card_digits(55, 2, 16), 1'b1));
    add_card(luhn_set(card_digits(50, 2, 16), 1'b1));
    add_card(luhn_set(card_digits(56, 2, 16), 1'b1));
    add_card(luhn_set(card_digits(53, 2, 16), 1'b0));
    add_card(luhn_set(card_digits(4, 1, 13), 1'b1));
    add_card(luhn_set(card_digits(4, 1, 16), 1'b1));
    add_card(luhn_set(card_digits(4, 1, 14), 1'b1));
    add_card(luhn_set(card_digits(4, 1, 15), 1'b1));
    add_card(luhn_set(card_digits(4, 1, 16), 1'b0));
    add_card(luhn_set(card_digits(37, 2, 16), 1'b1));
    add_card(luhn_set(card_digits(52, 2, 13), 1'b1));

    for (int i = 0; i < 2000; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 4))
          0: v = card_digits($urandom_range(0, 1) ? 34 : 37, 2, 15);
          1: v = card_digits(64'($urandom_range(51, 55)), 2, 16);
          2: v = card_digits(4, 1, 13);
          3: v = card_digits(4, 1, 16);
          default: begin
            len = $urandom_range(12, 16);
            v = card_digits(64'($urandom_range(10, 99)), 2, len);
          end
        endcase
        v = luhn_set(v, $urandom_range(0, 99) < 80);
      end else if (pick < 85) begin
        len = $urandom_range(1, 16);
        v = card_digits(64'($urandom_range(1, 9)), 1, len);
      end else begin
        v = {$urandom, $urandom};
        v = v & ((64'd1 << IN_W) - 1);
        if ($urandom_range(0, 1)) v = v >> $urandom_range(0, IN_W - 1);
      end
      add_card(v, i == 0 || i == 1000);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (card_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
